@@ rtl/nfa_char_matcher_top_macros.svh @@
// Assertion macros shared by the NFA matcher modules.
// Used by nfacm_ctrl and nfacm_dp; no other dependencies.
`ifndef NFA_CHAR_MATCHER_TOP_MACROS_SVH
`define NFA_CHAR_MATCHER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define NFACM_CHK_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define NFACM_CHK_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/nfacm_pkg.sv @@
// Shared types and constants for the NFA character matcher.
// No dependencies; used by nfacm_ctrl, nfacm_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package nfacm_pkg;

    localparam int NUM_STATES    = 16;
    localparam int NUM_EDGES     = 32;
    localparam int STATE_W       = $clog2(NUM_STATES);
    localparam int LABEL_W       = 8;
    localparam int EDGE_AW       = $clog2(NUM_EDGES);
    localparam int IDX_W         = $clog2(NUM_EDGES + 1);
    localparam int ENTRY_W       = 2 * STATE_W + LABEL_W;
    localparam int OP_W          = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int EDGE_COUNT_W  = 6;

    localparam logic [LABEL_W-1:0] EPS_LABEL = 8'd0;
    localparam logic [LABEL_W-1:0] ANY_LABEL = 8'd46;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_EDGE  = 2'd1,
        OP_SCAN  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START = 2'd0,
        CFG_FINAL = 2'd1,
        CFG_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ADV  = 4'b0010,
        ST_EPS  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    typedef struct packed {
        logic load_start;   // set := start state, begin closure
        logic load_scan;    // capture symbol, clear next set
        logic write_edge;
        logic run_adv;
        logic run_eps;
        logic to_eps;       // set := next set, begin closure
        logic restart;      // another closure pass
        logic out_now;      // result from current set and input last
        logic out_fin;      // result from current set and held last
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic changed;
        logic set_empty;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/nfacm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nfacm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/nfacm_ctrl.sv @@
// Controller FSM for the NFA matcher: handshakes, op decode, scan sequencing.
// Depends on nfacm_pkg and nfa_char_matcher_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "nfa_char_matcher_top_macros.svh"

module nfacm_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [nfacm_pkg::OP_W-1:0] i_op,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    input  wire nfacm_pkg::t_dp_sts        i_sts,
    output nfacm_pkg::t_dp_cmd             o_cmd
);

    nfacm_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;
    logic in_acc;
    logic out_load;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == nfacm_pkg::ST_IDLE) && out_free);
    assign o_out_valid = r_out_valid;
    assign out_load   = o_cmd.out_now || o_cmd.out_fin;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        in_acc  = 1'b0;
        unique case (r_state)
            nfacm_pkg::ST_IDLE: begin
                if (i_in_valid && out_free) begin
                    in_acc = 1'b1;
                    case (nfacm_pkg::t_op'(i_op))
                        nfacm_pkg::OP_START: begin
                            o_cmd.load_start = 1'b1;
                            n_state = nfacm_pkg::ST_EPS;
                        end
                        nfacm_pkg::OP_SCAN: begin
                            // an empty set stays empty: answer at once
                            if (i_sts.set_empty) begin
                                o_cmd.out_now = 1'b1;
                            end else begin
                                o_cmd.load_scan = 1'b1;
                                n_state = nfacm_pkg::ST_ADV;
                            end
                        end
                        nfacm_pkg::OP_EDGE: begin
                            o_cmd.write_edge = 1'b1;
                            o_cmd.out_now    = 1'b1;
                        end
                        default: begin
                            o_cmd.out_now = 1'b1;
                        end
                    endcase
                end
            end
            nfacm_pkg::ST_ADV: begin
                if (i_sts.scan_done) begin
                    o_cmd.to_eps = 1'b1;
                    n_state = nfacm_pkg::ST_EPS;
                end else begin
                    o_cmd.run_adv = 1'b1;
                end
            end
            nfacm_pkg::ST_EPS: begin
                if (i_sts.scan_done) begin
                    if (i_sts.changed) begin
                        o_cmd.restart = 1'b1;
                    end else begin
                        n_state = nfacm_pkg::ST_FIN;
                    end
                end else begin
                    o_cmd.run_eps = 1'b1;
                end
            end
            nfacm_pkg::ST_FIN: begin
                if (out_free) begin
                    o_cmd.out_fin = 1'b1;
                    n_state = nfacm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nfacm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nfacm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `NFACM_CHK_NXT(a_fin_emits, i_clk, i_rst_n, (r_state == nfacm_pkg::ST_FIN) && out_free, o_out_valid && (r_state == nfacm_pkg::ST_IDLE), "finished item did not reach the output register")
    `NFACM_CHK_NXT(a_adv_to_eps, i_clk, i_rst_n, r_state == nfacm_pkg::ST_ADV, (r_state == nfacm_pkg::ST_ADV) || (r_state == nfacm_pkg::ST_EPS), "edge step left without a closure")
    `NFACM_CHK_NXT(a_scan_starts, i_clk, i_rst_n, in_acc && (i_op == nfacm_pkg::OP_SCAN) && !i_sts.set_empty, r_state == nfacm_pkg::ST_ADV, "scan of a live set did not start an edge step")

endmodule

`default_nettype wire

@@ rtl/nfacm_dp.sv @@
// Datapath for the NFA matcher: config registers, edge table, state sets, result register.
// Depends on nfacm_pkg, nfacm_ram and nfa_char_matcher_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "nfa_char_matcher_top_macros.svh"

module nfacm_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [nfacm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [nfacm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic [nfacm_pkg::EDGE_AW-1:0]      i_edge_index,
    input  wire logic [nfacm_pkg::STATE_W-1:0]      i_edge_from,
    input  wire logic [nfacm_pkg::STATE_W-1:0]      i_edge_to,
    input  wire logic [nfacm_pkg::LABEL_W-1:0]      i_edge_label,
    input  wire logic [nfacm_pkg::LABEL_W-1:0]      i_symbol,
    input  wire logic                               i_last,
    input  wire nfacm_pkg::t_dp_cmd                 i_cmd,
    output nfacm_pkg::t_dp_sts                      o_sts,
    output logic                                    o_alive,
    output logic                                    o_accept,
    output logic                                    o_string_end
);

    localparam int NS = nfacm_pkg::NUM_STATES;
    localparam int SW = nfacm_pkg::STATE_W;
    localparam int LW = nfacm_pkg::LABEL_W;
    localparam int EW = nfacm_pkg::ENTRY_W;
    localparam int IW = nfacm_pkg::IDX_W;

    logic [SW-1:0]  r_start_state;
    logic [NS-1:0]  r_final_mask;
    logic [nfacm_pkg::EDGE_COUNT_W-1:0] r_edge_count;

    logic [NS-1:0]  r_set;
    logic [NS-1:0]  r_next;
    logic [LW-1:0]  r_sym;
    logic           r_last;
    logic [IW-1:0]  r_idx;
    logic           r_pv;
    logic           r_changed;

    logic [IW-1:0]  n_use;
    logic [EW-1:0]  rd_data;
    logic [SW-1:0]  e_from;
    logic [SW-1:0]  e_to;
    logic [LW-1:0]  e_label;
    logic           eps_hit;
    logic           adv_hit;
    logic           running;

    nfacm_ram #(
        .WIDTH (EW),
        .DEPTH (nfacm_pkg::NUM_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write_edge),
        .i_waddr (i_edge_index),
        .i_wdata ({i_edge_from, i_edge_to, i_edge_label}),
        .i_raddr (r_idx[nfacm_pkg::EDGE_AW-1:0]),
        .o_rdata (rd_data)
    );

    // entries beyond the table size are not used
    always_comb begin
        if (r_edge_count > nfacm_pkg::EDGE_COUNT_W'(nfacm_pkg::NUM_EDGES)) begin
            n_use = IW'(nfacm_pkg::NUM_EDGES);
        end else begin
            n_use = IW'(r_edge_count);
        end
    end

    assign e_from  = rd_data[EW-1 -: SW];
    assign e_to    = rd_data[LW +: SW];
    assign e_label = rd_data[LW-1:0];
    assign running = i_cmd.run_adv || i_cmd.run_eps;

    assign eps_hit = i_cmd.run_eps && r_pv && (e_label == nfacm_pkg::EPS_LABEL)
                     && r_set[e_from];
    assign adv_hit = i_cmd.run_adv && r_pv && (e_label != nfacm_pkg::EPS_LABEL)
                     && ((e_label == nfacm_pkg::ANY_LABEL) || (e_label == r_sym))
                     && r_set[e_from];

    assign o_sts.scan_done = (r_idx >= n_use) && !r_pv;
    assign o_sts.changed   = r_changed;
    assign o_sts.set_empty = (r_set == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_final_mask  <= '0;
            r_edge_count  <= '0;
        end else if (i_cfg_we) begin
            unique case (nfacm_pkg::t_cfg_idx'(i_cfg_index))
                nfacm_pkg::CFG_START: r_start_state <= i_cfg_wdata[SW-1:0];
                nfacm_pkg::CFG_FINAL: r_final_mask  <= i_cfg_wdata[NS-1:0];
                nfacm_pkg::CFG_COUNT: begin
                    r_edge_count <= i_cfg_wdata[nfacm_pkg::EDGE_COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // scan sequencer: one read issued per cycle, processed when the data returns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_pv      <= 1'b0;
            r_changed <= 1'b0;
            r_set     <= '0;
        end else begin
            if (i_cmd.load_start || i_cmd.load_scan || i_cmd.to_eps || i_cmd.restart) begin
                r_idx <= '0;
                r_pv  <= 1'b0;
            end else if (running) begin
                if (r_idx < n_use) begin
                    r_idx <= r_idx + IW'(1);
                    r_pv  <= 1'b1;
                end else begin
                    r_pv  <= 1'b0;
                end
            end

            if (i_cmd.load_start || i_cmd.to_eps || i_cmd.restart) begin
                r_changed <= 1'b0;
            end else if (eps_hit && !r_set[e_to]) begin
                r_changed <= 1'b1;
            end

            if (i_cmd.load_start) begin
                r_set <= NS'(1) << r_start_state;
            end else if (i_cmd.to_eps) begin
                r_set <= r_next;
            end else if (eps_hit) begin
                r_set[e_to] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_scan) begin
            r_next <= '0;
            r_sym  <= i_symbol;
        end else if (adv_hit) begin
            r_next[e_to] <= 1'b1;
        end
        if (i_cmd.load_start || i_cmd.load_scan) begin
            r_last <= i_last;
        end
        if (i_cmd.out_now || i_cmd.out_fin) begin
            o_alive      <= (r_set != '0);
            o_accept     <= ((r_set & r_final_mask) != '0);
            o_string_end <= i_cmd.out_now ? i_last : r_last;
        end
    end

    `NFACM_CHK_NOW(a_pv_has_issue, i_clk, i_rst_n, r_pv, r_idx != '0, "edge data valid with no read issued")
    `NFACM_CHK_NXT(a_eps_grows, i_clk, i_rst_n, i_cmd.run_eps, (r_set & $past(r_set)) == $past(r_set), "closure pass dropped a state")
    `NFACM_CHK_NXT(a_adv_grows, i_clk, i_rst_n, i_cmd.run_adv, (r_next & $past(r_next)) == $past(r_next), "edge step dropped a target state")

endmodule

`default_nettype wire

@@ rtl/nfa_char_matcher_top.sv @@
// Top level of the NFA character matcher: controller FSM plus datapath.
// Depends on nfacm_pkg, nfacm_ctrl, nfacm_dp (and through it nfacm_ram).
//
// channel  direction  handshake                  payload
// input    in         i_in_valid / o_in_stall    i_op, i_edge_*, i_symbol, i_last
// result   out        o_out_valid / i_out_stall  o_alive, o_accept, o_string_end
// config   in         i_cfg_we                   i_cfg_index, i_cfg_wdata
//
// n = min(edge_count, 32); P = closure passes (at least 1, the last one finds no change).
// Edge write, unused op, or scan of an empty set: result loaded at acceptance.
// Start item: P closure passes; scan item: an edge step, then P closure passes; each step
// or pass reads the n table entries, one edge table read per cycle through a single RAM port.
// Reset is synchronous: clears the state set and config registers; the edge table is not cleared.
// The result register holds through output stalls; a new item is taken when idle and it is free.
`timescale 1ns / 1ps
`default_nettype none

module nfa_char_matcher_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [nfacm_pkg::OP_W-1:0]          i_op,
    input  wire logic [nfacm_pkg::EDGE_AW-1:0]       i_edge_index,
    input  wire logic [nfacm_pkg::STATE_W-1:0]       i_edge_from,
    input  wire logic [nfacm_pkg::STATE_W-1:0]       i_edge_to,
    input  wire logic [nfacm_pkg::LABEL_W-1:0]       i_edge_label,
    input  wire logic [nfacm_pkg::LABEL_W-1:0]       i_symbol,
    input  wire logic                                i_last,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_alive,
    output logic                                     o_accept,
    output logic                                     o_string_end,
    input  wire logic                                i_cfg_we,
    input  wire logic [nfacm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [nfacm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    nfacm_pkg::t_dp_cmd cmd;
    nfacm_pkg::t_dp_sts sts;

    nfacm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    nfacm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_edge_index (i_edge_index),
        .i_edge_from  (i_edge_from),
        .i_edge_to    (i_edge_to),
        .i_edge_label (i_edge_label),
        .i_symbol     (i_symbol),
        .i_last       (i_last),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_alive      (o_alive),
        .o_accept     (o_accept),
        .o_string_end (o_string_end)
    );

endmodule

`default_nettype wire
